>>> src/ws2812_pixel_line_driver_unit_defines.svh
// Assertion macros for the pixel line driver.
// No dependencies; included by the modules that carry assertions.
`ifndef WS2812_PIXEL_LINE_DRIVER_UNIT_DEFINES_SVH
`define WS2812_PIXEL_LINE_DRIVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define WSPLD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// next-cycle implication
`define WSPLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define WSPLD_ASSERT_NOW(lbl, ante, cons)
`define WSPLD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/ws2812pld_pkg.sv
// Package for the pixel line driver: transaction types, opcodes, register
// indexes, reset values and the color scaling function. No dependencies.
package ws2812pld_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COLOR_W    = 24;

    localparam logic [4:0] BIT_LAST = 5'd23;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD  = 3'd4;

    localparam logic [7:0]  RST_BRIGHTNESS  = 8'd255;
    localparam logic [7:0]  RST_PIXEL_COUNT = 8'd1;
    localparam logic [15:0] RST_ZERO_HIGH   = 16'd60;
    localparam logic [15:0] RST_ONE_HIGH    = 16'd124;
    localparam logic [15:0] RST_BIT_PERIOD  = 16'd186;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
    } out_item_t;

    // (v * b) >> 8
    function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [7:0] b);
        logic [15:0] prod;
        prod = 16'(v) * 16'(b);
        return prod[15:8];
    endfunction

endpackage

>>> src/ws2812_pixel_line_driver_unit.sv
// Pixel line driver: input register, one pass of timing/scaling logic, result register.
// Depends on ws2812pld_pkg and ws2812_pixel_line_driver_unit_defines.svh.
//
// Accepted transactions pass through the input register to the result register.
// Throughput: one transaction per cycle unless out_ready stalls; a tick steps the line.
// Reset (rst_n low, async): idle, line low, registers at their reset values.
`include "ws2812_pixel_line_driver_unit_defines.svh"

module ws2812_pixel_line_driver_unit #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  ws2812pld_pkg::in_item_t                  in_data,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output ws2812pld_pkg::out_item_t                 out_data,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ws2812pld_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ws2812pld_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ws2812pld_pkg::*;

    // compare width: covers the cycle counter and the 16-bit timings, plus a carry
    localparam int CMP_W = ((COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16) + 1;

    // ---------------------------------------------------------------------
    // Configuration registers. Writes take effect at once, also while a
    // frame is on the wire; the port is always ready. Out-of-range indexes
    // are dropped.
    // ---------------------------------------------------------------------
    logic [7:0]  brightness_reg;
    logic [7:0]  pixel_count_reg;
    logic [15:0] zero_high_reg;
    logic [15:0] one_high_reg;
    logic [15:0] bit_period_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg  <= RST_BRIGHTNESS;
            pixel_count_reg <= RST_PIXEL_COUNT;
            zero_high_reg   <= RST_ZERO_HIGH;
            one_high_reg    <= RST_ONE_HIGH;
            bit_period_reg  <= RST_BIT_PERIOD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BRIGHTNESS:  brightness_reg  <= cfg_data[7:0];
                REG_PIXEL_COUNT: pixel_count_reg <= cfg_data[7:0];
                REG_ZERO_HIGH:   zero_high_reg   <= cfg_data;
                REG_ONE_HIGH:    one_high_reg    <= cfg_data;
                REG_BIT_PERIOD:  bit_period_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input register. Processing fires when the result register is empty
    // or is handing off its transaction in this cycle.
    // ---------------------------------------------------------------------
    logic     s1_valid_reg;
    in_item_t s1_data_reg;
    logic     out_valid_reg;
    out_item_t out_data_reg;
    logic     s1_fire;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    // ---------------------------------------------------------------------
    // Line state: color shift word, bit and pixel position, cycle counter.
    // ---------------------------------------------------------------------
    logic [COLOR_W-1:0]       color_bits_reg, color_bits_next;
    logic [4:0]               bit_index_reg, bit_index_next;
    logic [7:0]               pixel_index_reg, pixel_index_next;
    logic [COUNTER_WIDTH-1:0] cycle_count_reg, cycle_count_next;
    logic                     active_reg, active_next;
    out_item_t                result;

    logic                     cur_bit;
    logic [15:0]              cur_high;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         high_ext;
    logic [CMP_W-1:0]         period_ext;
    logic [CMP_W-1:0]         bit_len;
    logic                     level_now;
    logic                     cnt_sat;
    logic [COLOR_W-1:0]       new_color;
    logic [15:0]              new_high;

    always_comb
    begin
        // bit 0 of the sequence is bit 23 of the color word (MSB of green)
        cur_bit    = color_bits_reg[BIT_LAST - bit_index_reg];
        cur_high   = cur_bit ? one_high_reg : zero_high_reg;
        cnt_ext    = CMP_W'(cycle_count_reg);
        high_ext   = CMP_W'(cur_high);
        period_ext = CMP_W'(bit_period_reg);
        // a bit's length is max(high, period), never zero
        bit_len    = (high_ext > period_ext) ? high_ext : period_ext;
        if (bit_len == '0)
        begin
            bit_len = CMP_W'(1);
        end
        level_now  = active_reg && (cnt_ext < high_ext);
        cnt_sat    = &cycle_count_reg;

        // send order is green, red, blue
        new_color  = {scale_byte(s1_data_reg.green, brightness_reg),
                      scale_byte(s1_data_reg.red,   brightness_reg),
                      scale_byte(s1_data_reg.blue,  brightness_reg)};
        new_high   = new_color[COLOR_W-1] ? one_high_reg : zero_high_reg;

        color_bits_next  = color_bits_reg;
        bit_index_next   = bit_index_reg;
        pixel_index_next = pixel_index_reg;
        cycle_count_next = cycle_count_reg;
        active_next      = active_reg;
        result.line_level = level_now;
        result.busy_res   = active_reg;

        if (s1_fire)
        begin
            if (s1_data_reg.opcode == OP_WRITE)
            begin
                // a write while busy is dropped and reports the current cycle
                if (!active_reg)
                begin
                    color_bits_next  = new_color;
                    bit_index_next   = '0;
                    pixel_index_next = '0;
                    cycle_count_next = '0;
                    active_next      = (pixel_count_reg != 8'd0);
                    result.line_level = (pixel_count_reg != 8'd0) && (new_high != 16'd0);
                    result.busy_res   = (pixel_count_reg != 8'd0);
                end
            end
            else if (active_reg)
            begin
                // tick: report this cycle, then step the line once
                if (((cnt_ext + CMP_W'(1)) < bit_len) && !cnt_sat)
                begin
                    cycle_count_next = cycle_count_reg + COUNTER_WIDTH'(1);
                end
                else
                begin
                    cycle_count_next = '0;
                    if (bit_index_reg < BIT_LAST)
                    begin
                        bit_index_next = bit_index_reg + 5'd1;
                    end
                    else
                    begin
                        bit_index_next = '0;
                        if ((9'(pixel_index_reg) + 9'd1) < 9'(pixel_count_reg))
                        begin
                            pixel_index_next = pixel_index_reg + 8'd1;
                        end
                        else
                        begin
                            pixel_index_next = '0;
                            active_next      = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_bits_reg  <= '0;
            bit_index_reg   <= '0;
            pixel_index_reg <= '0;
            cycle_count_reg <= '0;
            active_reg      <= 1'b0;
        end
        else
        begin
            color_bits_reg  <= color_bits_next;
            bit_index_reg   <= bit_index_next;
            pixel_index_reg <= pixel_index_next;
            cycle_count_reg <= cycle_count_next;
            active_reg      <= active_next;
        end
    end

    // ---------------------------------------------------------------------
    // Result register: holds a finished transaction until it is taken.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // idle means all position state is back at zero
    `WSPLD_ASSERT_NOW(a_idle_zero, !active_reg, (cycle_count_reg == '0) && (bit_index_reg == '0) && (pixel_index_reg == '0))
    // bit position never runs past the last color bit
    `WSPLD_ASSERT_NOW(a_bit_range, 1'b1, bit_index_reg <= BIT_LAST)
    // a high line is only ever reported while sending
    `WSPLD_ASSERT_NOW(a_level_busy, out_valid_reg, !out_data_reg.line_level || out_data_reg.busy_res)
    // a tick while idle leaves the block idle
    `WSPLD_ASSERT_NEXT(a_tick_idle, s1_fire && (s1_data_reg.opcode == OP_TICK) && !active_reg, !active_reg)

endmodule

>>> tb/sv/ws2812_pixel_line_driver_unit_tb.sv
// Self-checking testbench for ws2812_pixel_line_driver_unit: directed table, then random phases.
// Depends on ws2812pld_pkg and the RTL of the pixel line driver.
// Every accepted transaction is scored against the in-bench line predictor or a typed row result.
module ws2812_pixel_line_driver_unit_tb;
    import ws2812pld_pkg::*;

    localparam int CNT_W          = 16;
    localparam int CYCLE_MAX      = (1 << CNT_W) - 1;
    // longest quiet stretch: sender gap + receiver stall + pipeline + settle, many times over
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1550;
    // pause before each register write, once every result has been checked
    localparam int SETTLE_CYCLES  = 4;

    typedef enum logic { ROW_REG, ROW_ITEM } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_idx;
        logic [CFG_DATA_W-1:0]    reg_val;
        in_item_t                 item;
        int                       rep;
        bit                       typed;
        out_item_t                typed_res;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    in_item_t                in_data = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    out_item_t               out_data;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    ws2812_pixel_line_driver_unit #(
        .COUNTER_WIDTH(CNT_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line predictor: register copies and sender state, updated at each
    // accepted transaction and each accepted register write.
    // ------------------------------------------------------------------
    logic [7:0]   cur_brightness  = RST_BRIGHTNESS;
    logic [7:0]   cur_pixel_count = RST_PIXEL_COUNT;
    logic [15:0]  cur_zero_high   = RST_ZERO_HIGH;
    logic [15:0]  cur_one_high    = RST_ONE_HIGH;
    logic [15:0]  cur_bit_period  = RST_BIT_PERIOD;

    logic [23:0]  grb_bits  = '0;   // scaled color, green on top
    logic [4:0]   bit_pos   = '0;   // 0 is bit 23
    logic [7:0]   pixel_pos = '0;
    int unsigned  cycle_pos = 0;
    bit           sending   = 1'b0;

    out_item_t    expected_samples[$];

    // run bookkeeping
    int  fail_count   = 0;
    int  n_items      = 0;
    int  n_loads      = 0;
    int  n_ignored    = 0;
    int  n_reg_writes = 0;
    int  n_checked    = 0;
    int  idle_cycles  = 0;
    bit  in_steady    = 1'b0;  // sender draws no gaps when set
    bit  out_steady   = 1'b0;  // receiver never stalls when set

    stim_row_t plan[$];

    function automatic logic [7:0] dim_byte(input logic [7:0] v);
        logic [15:0] prod;
        prod = 16'(v) * 16'(cur_brightness);
        return prod[15:8];
    endfunction

    function automatic int unsigned high_time();
        return 32'(grb_bits[23 - bit_pos] ? cur_one_high : cur_zero_high);
    endfunction

    function automatic logic level_now();
        return sending && (cycle_pos < high_time());
    endfunction

    // one step of the wire while sending
    task automatic step_clock();
        int unsigned len;
        int unsigned hi;
        hi  = high_time();
        len = 32'(cur_bit_period);
        if (hi > len)
            len = hi;
        if (len == 0)
            len = 1;   // a bit's length is never zero
        if (cycle_pos + 1 < len && cycle_pos < CYCLE_MAX)
            cycle_pos++;
        else
        begin
            cycle_pos = 0;
            if (bit_pos < BIT_LAST)
                bit_pos++;
            else
            begin
                bit_pos = '0;
                // a pixel count lowered mid-frame ends the frame here
                if (int'(pixel_pos) + 1 < int'(cur_pixel_count))
                    pixel_pos++;
                else
                begin
                    pixel_pos = '0;
                    sending   = 1'b0;
                end
            end
        end
    endtask

    task automatic predict_sample(input in_item_t it, output out_item_t res);
        if (it.opcode == OP_WRITE)
        begin
            // a color load only lands when idle; otherwise the write is dropped
            if (!sending)
            begin
                grb_bits  = {dim_byte(it.green), dim_byte(it.red), dim_byte(it.blue)};
                bit_pos   = '0;
                pixel_pos = '0;
                cycle_pos = 0;
                sending   = (cur_pixel_count != 0);
                n_loads++;
            end
            else
                n_ignored++;
            res.line_level = level_now();
            res.busy_res   = sending;
        end
        else
        begin
            // sample the current cycle, then let time move on
            res.line_level = level_now();
            res.busy_res   = sending;
            if (sending)
                step_clock();
        end
    endtask

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic in_item_t make_item(input logic op);
        in_item_t it;
        it.opcode = op;
        it.red    = 8'($urandom_range(0, 255));
        it.green  = 8'($urandom_range(0, 255));
        it.blue   = 8'($urandom_range(0, 255));
        // pin the color to full or dark now and then
        case ($urandom_range(0, 7))
            0: begin it.red = 8'hff; it.green = 8'hff; it.blue = 8'hff; end
            1: begin it.red = 8'h00; it.green = 8'h00; it.blue = 8'h00; end
            default: ;
        endcase
        return it;
    endfunction

    function automatic logic [15:0] draw_timing();
        case ($urandom_range(0, 15))
            0:       return 16'd0;
            1:       return 16'hffff;
            2:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side. A transaction leaves valid high at its accepting edge;
    // the next call either reuses it (no gap) or lowers it in that step.
    // ------------------------------------------------------------------
    task automatic issue_item(input in_item_t it, input bit typed, input out_item_t typed_res);
        int        gap;
        out_item_t res;
        gap = draw_gap(in_steady);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_sample(it, res);
        expected_samples.push_back(typed ? typed_res : res);
        n_items++;
    endtask

    task automatic drain_samples();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    // register writes only go in with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BRIGHTNESS:  cur_brightness  = val[7:0];
            REG_PIXEL_COUNT: cur_pixel_count = val[7:0];
            REG_ZERO_HIGH:   cur_zero_high   = val;
            REG_ONE_HIGH:    cur_one_high    = val;
            REG_BIT_PERIOD:  cur_bit_period  = val;
            default: ;
        endcase
        n_reg_writes++;
    endtask

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row.kind      = ROW_REG;
        row.reg_idx   = idx;
        row.reg_val   = val;
        row.item      = '0;
        row.rep       = 1;
        row.typed     = 1'b0;
        row.typed_res = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(input logic op, input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input int rep, input bit typed,
                                      input logic lvl, input logic busy);
        stim_row_t row;
        row.kind                 = ROW_ITEM;
        row.reg_idx              = '0;
        row.reg_val              = '0;
        row.item.opcode          = op;
        row.item.red             = r;
        row.item.green           = g;
        row.item.blue            = b;
        row.rep                  = rep;
        row.typed                = typed;
        row.typed_res.line_level = lvl;
        row.typed_res.busy_res   = busy;
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: stall drawn per result, check against oldest entry.
    // ------------------------------------------------------------------
    initial
    begin
        int        stall;
        out_item_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(out_steady);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (expected_samples.size() == 0)
            begin
                $error("unexpected result: line_level=%0b busy_res=%0b",
                       out_data.line_level, out_data.busy_res);
                fail_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (out_data.line_level !== want.line_level)
                begin
                    $error("line_level: expected %0b, got %0b",
                           want.line_level, out_data.line_level);
                    fail_count++;
                end
                if (out_data.busy_res !== want.busy_res)
                begin
                    $error("busy_res: expected %0b, got %0b",
                           want.busy_res, out_data.busy_res);
                    fail_count++;
                end
                n_checked++;
            end
        end
    end

    // watchdog: any accepted transaction, taken result or register write resets it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("ws2812_pixel_line_driver_unit_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int        phase_end;
        int        tick_budget;
        int        pick;
        out_item_t none;

        none = '0;

        // directed part; typed results only where they are obvious
        plan_item(OP_TICK, 8'h00, 8'h00, 8'h00, 1, 1'b1, 1'b0, 1'b0);   // idle out of reset
        plan_reg(REG_PIXEL_COUNT, 16'd0);
        plan_item(OP_WRITE, 8'hff, 8'hff, 8'hff, 1, 1'b1, 1'b0, 1'b0);  // no pixels: stays idle
        plan_reg(REG_PIXEL_COUNT, 16'd1);
        plan_item(OP_WRITE, 8'hff, 8'hff, 8'hff, 1, 1'b1, 1'b1, 1'b1);  // first bit is a one
        plan_item(OP_WRITE, 8'h00, 8'h00, 8'h00, 1, 1'b1, 1'b1, 1'b1);  // dropped while busy
        plan_item(OP_TICK, 8'h00, 8'h00, 8'h00, 2, 1'b0, 1'b0, 1'b0);
        // zero timings while a frame is on the wire: shortest bits, line low
        plan_reg(REG_BIT_PERIOD, 16'd0);
        plan_reg(REG_ZERO_HIGH, 16'd0);
        plan_reg(REG_ONE_HIGH, 16'd0);
        plan_item(OP_TICK, 8'h5a, 8'ha5, 8'h3c, 4, 1'b0, 1'b0, 1'b0);
        // high time longer than the period stretches the bit
        plan_reg(REG_ONE_HIGH, 16'd5);
        plan_reg(REG_BIT_PERIOD, 16'd2);
        plan_item(OP_TICK, 8'h00, 8'h00, 8'h00, 6, 1'b0, 1'b0, 1'b0);
        // pixel count dropped under the current pixel mid-frame
        plan_reg(REG_PIXEL_COUNT, 16'd0);
        plan_item(OP_TICK, 8'h00, 8'h00, 8'h00, 3, 1'b0, 1'b0, 1'b0);
        // extremes
        plan_reg(REG_BRIGHTNESS, 16'd0);
        plan_reg(REG_PIXEL_COUNT, 16'd255);
        plan_reg(REG_ZERO_HIGH, 16'hffff);
        plan_reg(REG_ONE_HIGH, 16'hffff);
        plan_reg(REG_BIT_PERIOD, 16'hffff);
        plan_item(OP_TICK, 8'h00, 8'h00, 8'h00, 2, 1'b0, 1'b0, 1'b0);
        plan_item(OP_WRITE, 8'h12, 8'h34, 8'h56, 1, 1'b0, 1'b0, 1'b0);
        plan_reg(REG_BRIGHTNESS, 16'd128);
        plan_reg(REG_PIXEL_COUNT, 16'd2);
        plan_reg(REG_ZERO_HIGH, 16'd1);
        plan_reg(REG_ONE_HIGH, 16'd3);
        plan_reg(REG_BIT_PERIOD, 16'd2);
        plan_item(OP_WRITE, 8'h80, 8'hff, 8'h01, 1, 1'b0, 1'b0, 1'b0);
        plan_item(OP_TICK, 8'h00, 8'h00, 8'h00, 4, 1'b0, 1'b0, 1'b0);

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                repeat (plan[i].rep) issue_item(plan[i].item, plan[i].typed, plan[i].typed_res);
        end

        // random phases: new register set, then mostly complete frames
        while (n_items < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       write_reg(REG_BRIGHTNESS, 16'd0);
                1:       write_reg(REG_BRIGHTNESS, 16'd255);
                default: write_reg(REG_BRIGHTNESS, 16'($urandom_range(0, 255)));
            endcase
            case ($urandom_range(0, 19))
                0:       write_reg(REG_PIXEL_COUNT, 16'd0);
                1:       write_reg(REG_PIXEL_COUNT, 16'd255);
                default: write_reg(REG_PIXEL_COUNT, 16'($urandom_range(1, 3)));
            endcase
            write_reg(REG_ZERO_HIGH, draw_timing());
            write_reg(REG_ONE_HIGH, draw_timing());
            write_reg(REG_BIT_PERIOD, draw_timing());

            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            phase_end  = n_items + $urandom_range(90, 130);
            if (phase_end > ITEM_TARGET)
                phase_end = ITEM_TARGET;

            while (n_items < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    // load a color and clock it out, with a stray write now and then
                    issue_item(make_item(OP_WRITE), 1'b0, none);
                    tick_budget = $urandom_range(20, 300);
                    while (sending && tick_budget > 0 && n_items < phase_end)
                    begin
                        if ($urandom_range(0, 15) == 0)
                            issue_item(make_item(OP_WRITE), 1'b0, none);
                        else
                            issue_item(make_item(OP_TICK), 1'b0, none);
                        tick_budget--;
                    end
                end
                else
                    issue_item(make_item(pick[0] ? OP_WRITE : OP_TICK), 1'b0, none);

                // sender holds off until every result is back
                if ($urandom_range(0, 29) == 0)
                    drain_samples();
            end
        end

        drain_samples();
        repeat (10) @(posedge clk);

        $display("covered %0d transactions: %0d color loads, %0d writes dropped while busy",
                 n_items, n_loads, n_ignored);
        $display("%0d register writes, %0d results checked", n_reg_writes, n_checked);
        if (fail_count == 0)
            $display("ws2812_pixel_line_driver_unit_tb: PASS");
        else
            $display("ws2812_pixel_line_driver_unit_tb: FAIL");
        $finish;
    end

endmodule
